>>> rtl/irp_pkg.sv
package irp_pkg;

  localparam int MaxPoints = 1024;
  localparam int CountBits = 16;
  localparam int FracBits  = 16;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = AddrW + 1;
  localparam int SumW      = 26;
  localparam int FitW      = FracBits + 1;
  localparam int EntryW    = AddrW + 2 * SumW;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StBad     = 2'd2;
  localparam logic [1:0] StNoIndex = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] successes;
    logic [15:0] trials;
    logic [9:0]  index;
  } irp_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [25:0] block_successes;
    logic [25:0] block_trials;
    logic [16:0] fitted_value;
  } irp_rsp_t;

endpackage

>>> rtl/irp_ram.sv
module irp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/isotonic_regression_pava.sv
// Channel  | Signals                  | Direction | Note
// request  | start_i, busy_o, req_i   | in        | taken when start_i & !busy_o
// result   | done_o, rsp_o            | out       | one cycle, no backpressure
//
// Clear, op 3 and rejected requests go straight to the done state.
// Add: pushes the new block and merges it as needed, with a final compare
// unless the stack has emptied; the merge loop runs through the block stack
// memory (read top-1, compare by cross-multiplication, write back).
// Read: binary search, up to 11 probes (the last one fetching the block),
// then the bit-serial divider for the fitted value.
// Reset clears counters and control; the block memory needs no clearing.
// The receiver cannot stall: done_o is a single-cycle strobe.
module isotonic_regression_pava
  import irp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  irp_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output irp_rsp_t rsp_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SPush  = 4'd1;
  localparam logic [3:0] SMRd   = 4'd2;
  localparam logic [3:0] SMWait = 4'd3;
  localparam logic [3:0] SMMul  = 4'd4;
  localparam logic [3:0] SMCmp  = 4'd5;
  localparam logic [3:0] SBRd   = 4'd6;
  localparam logic [3:0] SBWait = 4'd7;
  localparam logic [3:0] SBChk  = 4'd8;
  localparam logic [3:0] SDiv   = 4'd9;
  localparam logic [3:0] SDone  = 4'd10;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] pcnt_q, pcnt_d, bcnt_q, bcnt_d;
  irp_rsp_t        rsp_q, rsp_d;
  // top-of-stack block held in registers
  logic [AddrW-1:0] tl_q, tl_d;
  logic [SumW-1:0]  ts_q, ts_d, tt_q, tt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [CntW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [51:0]      p1_q, p1_d, p2_q, p2_d;
  logic [SumW:0]    rem_q, rem_d;
  logic [FitW-1:0]  quo_q, quo_d;
  logic [4:0]       dcnt_q, dcnt_d;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [AddrW-1:0]  r_last;
  logic [SumW-1:0]   r_s, r_t;
  logic [CntW-1:0]   mid;
  logic [SumW:0]     rem_sh;

  assign {r_last, r_s, r_t} = rdata;
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign rem_sh = {rem_q[SumW-1:0], 1'b0};

  irp_ram #(.Width(EntryW), .Depth(MaxPoints)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q; pcnt_d = pcnt_q; bcnt_d = bcnt_q; rsp_d = rsp_q;
    tl_d = tl_q; ts_d = ts_q; tt_d = tt_q; idx_d = idx_q;
    lo_d = lo_q; hi_d = hi_q; p1_d = p1_q; p2_d = p2_q;
    rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q;
    we = 1'b0; waddr = '0; wdata = {tl_q, ts_q, tt_q}; raddr = '0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          rsp_d = '0;
          state_d = SDone;
          case (req_i.op)
            OpClear: begin
              pcnt_d = '0; bcnt_d = '0;
            end
            OpAdd: begin
              if (pcnt_q >= CntW'(MaxPoints)) begin
                rsp_d.status = StFull;
              end else if (req_i.trials == '0 || req_i.successes > req_i.trials) begin
                rsp_d.status = StBad;
              end else begin
                tl_d = pcnt_q[AddrW-1:0];
                ts_d = SumW'(req_i.successes);
                tt_d = SumW'(req_i.trials);
                pcnt_d = pcnt_q + 1'b1;
                state_d = SPush;
              end
            end
            OpRead: begin
              if (CntW'(req_i.index) >= pcnt_q) begin
                rsp_d.status = StNoIndex;
              end else begin
                idx_d = req_i.index;
                lo_d = '0; hi_d = bcnt_q - 1'b1;
                state_d = SBRd;
              end
            end
            default: ;
          endcase
        end
      end
      SPush: begin
        // new block sits in top regs at stack position bcnt_q
        if (bcnt_q == '0) begin
          waddr = '0; we = 1'b1; bcnt_d = CntW'(1); state_d = SDone;
        end else begin
          state_d = SMRd;
        end
      end
      SMRd: begin
        raddr = AddrW'(bcnt_q - 1'b1);
        state_d = SMWait;
      end
      SMWait: begin
        // keep the address so the read data stays valid through SMCmp
        raddr = AddrW'(bcnt_q - 1'b1);
        p1_d = r_s * tt_q;
        p2_d = ts_q * r_t;
        state_d = SMMul;
      end
      SMMul: begin
        raddr = AddrW'(bcnt_q - 1'b1);
        state_d = SMCmp;
      end
      SMCmp: begin
        if (p1_q > p2_q) begin
          ts_d = r_s + ts_q;
          tt_d = r_t + tt_q;
          bcnt_d = bcnt_q - 1'b1;
          state_d = SPush;
        end else begin
          waddr = AddrW'(bcnt_q); we = 1'b1;
          bcnt_d = bcnt_q + 1'b1;
          state_d = SDone;
        end
      end
      SBRd: begin
        raddr = AddrW'(lo_q < hi_q ? mid : lo_q);
        state_d = SBWait;
      end
      SBWait: begin
        raddr = AddrW'(lo_q < hi_q ? mid : lo_q);
        state_d = SBChk;
      end
      SBChk: begin
        if (lo_q < hi_q) begin
          if (r_last >= idx_q) hi_d = mid;
          else lo_d = mid + 1'b1;
          state_d = SBRd;
        end else begin
          rsp_d.block_successes = r_s;
          rsp_d.block_trials = r_t;
          tt_d = r_t;
          if ({1'b0, r_s} >= {1'b0, r_t}) begin
            rem_d = {1'b0, r_s} - {1'b0, r_t}; quo_d = FitW'(1);
          end else begin
            rem_d = {1'b0, r_s}; quo_d = '0;
          end
          dcnt_d = 5'(FracBits);
          state_d = SDiv;
        end
      end
      SDiv: begin
        if (dcnt_q == '0) begin
          rsp_d.fitted_value = quo_q;
          state_d = SDone;
        end else begin
          if (rem_sh >= {1'b0, tt_q}) begin
            rem_d = rem_sh - {1'b0, tt_q}; quo_d = {quo_q[FitW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh; quo_d = {quo_q[FitW-2:0], 1'b0};
          end
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; pcnt_q <= '0; bcnt_q <= '0;
    end else begin
      state_q <= state_d; pcnt_q <= pcnt_d; bcnt_q <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d; tl_q <= tl_d; ts_q <= ts_d; tt_q <= tt_d; idx_q <= idx_d;
    lo_q <= lo_d; hi_q <= hi_d; p1_q <= p1_d; p2_q <= p2_d;
    rem_q <= rem_d; quo_q <= quo_d; dcnt_q <= dcnt_d;
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = (state_q == SDone);
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_blocks_le_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= pcnt_q) else $error("more blocks than points");
  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request not taken");
`endif

endmodule
